// File: hdl/bplfb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bplfb_pkg
// Shared types and constants of the bit-plane LED frame buffer.
// ----------------------------------------------------------------------------
package bplfb_pkg;

	localparam int COLUMNS          = 200;
	localparam int BYTES_PER_COLUMN = 24;
	localparam int BYTES_PER_COLOR  = 8;
	localparam int COL_W            = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int WORD_W           = 8 * BYTES_PER_COLUMN;
	localparam int BYTE_IDX_W       = $clog2(BYTES_PER_COLUMN);

	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_START = 2'd1,
		KIND_CLEAR = 2'd2,
		KIND_TICK  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MODIFY,
		ST_TICK,
		ST_CLEAR
	} state_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  pixel_column;
		logic [2:0]  pixel_row;
		logic [7:0]  red_level;
		logic [7:0]  green_level;
		logic [7:0]  blue_level;
	} in_word_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last_byte;
	} out_word_t;

endpackage

// File: hdl/bit_plane_led_frame_buffer.sv
`timescale 1ns / 1ps
// A tick word's byte appears on result, with done high, once the column word read into
// rd_q is registered into result; a pixel write reads then writes back one column word.
// Writes and ticks hold busy while they run, so the next word waits; start keeps busy low.
// A clear holds busy while the column memory is zeroed, one column word a cycle.
// Reset: the same clearing pass runs after reset (busy high), no scan active.
// The receiver cannot stall: done is a one-cycle strobe.
// ----------------------------------------------------------------------------
// bit_plane_led_frame_buffer
// Frame store for an LED matrix kept as bit planes, one 24-byte word per
// column in a single-port synchronous memory, with a byte-serial scan out.
// ----------------------------------------------------------------------------
module bit_plane_led_frame_buffer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  bplfb_pkg::in_word_t  in_word,
	output logic                 done,
	output bplfb_pkg::out_word_t result
);

	localparam logic [bplfb_pkg::COL_W-1:0] LAST_COL =
		bplfb_pkg::COL_W'(bplfb_pkg::COLUMNS - 1);
	localparam logic [bplfb_pkg::BYTE_IDX_W-1:0] LAST_BYTE =
		bplfb_pkg::BYTE_IDX_W'(bplfb_pkg::BYTES_PER_COLUMN - 1);

	// column memory
	logic [bplfb_pkg::WORD_W-1:0] mem [bplfb_pkg::COLUMNS];
	logic [bplfb_pkg::WORD_W-1:0] rd_q;
	logic [bplfb_pkg::WORD_W-1:0] wr_data;
	logic [bplfb_pkg::COL_W-1:0]  mem_addr;
	logic                         mem_we;
	logic                         mem_re;

	bplfb_pkg::state_t state_q, state_d;

	logic                              accept;
	logic                              col_ok;
	bplfb_pkg::in_word_t               pix_q;
	logic [bplfb_pkg::COL_W-1:0]       clr_q;
	logic [bplfb_pkg::COL_W-1:0]       scan_col_q;
	logic [bplfb_pkg::BYTE_IDX_W-1:0]  scan_byte_q;
	logic                              scan_active_q;
	logic                              done_q;
	bplfb_pkg::out_word_t              result_q;
	logic                              scan_last;

	assign accept    = start && !busy;
	assign col_ok    = 32'(in_word.pixel_column) < bplfb_pkg::COLUMNS;
	assign scan_last = (scan_col_q == LAST_COL) && (scan_byte_q == LAST_BYTE);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bplfb_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (in_word.kind)
						bplfb_pkg::KIND_WRITE: if (col_ok) state_d = bplfb_pkg::ST_MODIFY;
						bplfb_pkg::KIND_START: state_d = bplfb_pkg::ST_IDLE;
						bplfb_pkg::KIND_CLEAR: state_d = bplfb_pkg::ST_CLEAR;
						bplfb_pkg::KIND_TICK:  if (scan_active_q) state_d = bplfb_pkg::ST_TICK;
						default:               state_d = bplfb_pkg::ST_IDLE;
					endcase
				end
			end
			bplfb_pkg::ST_MODIFY: state_d = bplfb_pkg::ST_IDLE;
			bplfb_pkg::ST_TICK:   state_d = bplfb_pkg::ST_IDLE;
			bplfb_pkg::ST_CLEAR:  if (clr_q == LAST_COL) state_d = bplfb_pkg::ST_IDLE;
			default:              state_d = bplfb_pkg::ST_IDLE;
		endcase
	end

	// outputs and memory control
	always_comb begin
		logic [7:0] lvl;
		logic [2:0] bitpos;
		lvl      = '0;
		wr_data  = rd_q;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		mem_addr = bplfb_pkg::COL_W'(in_word.pixel_column);
		busy     = (state_q != bplfb_pkg::ST_IDLE);
		bitpos   = 3'd7 - pix_q.pixel_row;
		unique case (state_q)
			bplfb_pkg::ST_IDLE: begin
				if (accept && in_word.kind == bplfb_pkg::KIND_TICK) begin
					mem_addr = scan_col_q;
				end
				mem_re = accept;
			end
			bplfb_pkg::ST_MODIFY: begin
				mem_addr = bplfb_pkg::COL_W'(pix_q.pixel_column);
				mem_we   = 1'b1;
				for (int c = 0; c < 3; c++) begin
					lvl = (c == 0) ? pix_q.red_level :
					      (c == 1) ? pix_q.green_level : pix_q.blue_level;
					for (int k = 0; k < bplfb_pkg::BYTES_PER_COLOR; k++) begin
						wr_data[8 * (c * bplfb_pkg::BYTES_PER_COLOR + k) + bitpos] =
							lvl[7 - k];
					end
				end
			end
			bplfb_pkg::ST_TICK: begin
				mem_addr = scan_col_q;
			end
			bplfb_pkg::ST_CLEAR: begin
				mem_addr = clr_q;
				mem_we   = 1'b1;
				wr_data  = '0;
			end
			default: begin
				mem_addr = clr_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rd_q <= mem[mem_addr];
		end
	end

	// hold the pixel word for the write back
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_q <= in_word;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == bplfb_pkg::ST_TICK) begin
			result_q.frame_byte <= rd_q[8 * scan_byte_q +: 8];
			result_q.last_byte  <= scan_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= bplfb_pkg::ST_CLEAR;
			clr_q         <= '0;
			scan_col_q    <= '0;
			scan_byte_q   <= '0;
			scan_active_q <= 1'b0;
			done_q        <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == bplfb_pkg::ST_TICK);
			if (state_q == bplfb_pkg::ST_CLEAR) begin
				clr_q <= (clr_q == LAST_COL) ? '0 : clr_q + 1'b1;
			end
			if (accept && (in_word.kind == bplfb_pkg::KIND_START ||
			               in_word.kind == bplfb_pkg::KIND_CLEAR)) begin
				scan_col_q    <= '0;
				scan_byte_q   <= '0;
				scan_active_q <= 1'b1;
			end else if (state_q == bplfb_pkg::ST_TICK) begin
				// advance the scan, drop it after the final byte
				if (scan_last) begin
					scan_col_q    <= '0;
					scan_byte_q   <= '0;
					scan_active_q <= 1'b0;
				end else if (scan_byte_q == LAST_BYTE) begin
					scan_byte_q <= '0;
					scan_col_q  <= scan_col_q + 1'b1;
				end else begin
					scan_byte_q <= scan_byte_q + 1'b1;
				end
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bit-plane LED frame buffer. Pixel writes,
// scan starts, clears and shift ticks are sent through the start/busy
// handshake. A shadow copy of the frame store predicts every scanned byte,
// and each strobed result is compared with the oldest predicted byte.
// ----------------------------------------------------------------------------
module testbench;
	import bplfb_pkg::*;

	localparam int FRAME_BYTES   = BYTES_PER_COLUMN * COLUMNS;
	localparam int RANDOM_WORDS  = 1370;
	localparam int QUIET_WORDS   = 300;
	localparam int SCAN_TICKS    = 480;
	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int PRINT_LIMIT   = 100;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	in_word_t  in_word;
	logic      done;
	out_word_t result;

	logic [7:0]  shadow_frame [FRAME_BYTES];
	int unsigned shadow_scan_pos;
	bit          shadow_scanning;
	out_word_t   pending_bytes [$];
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	bit          quiet_sender = 1'b0;

	bit_plane_led_frame_buffer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.in_word(in_word),
		.done   (done),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic report(input string what);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT)
			$display("[%0t] mismatch: %s", $time, what);
	endtask

	function automatic void wipe_shadow_frame();
		foreach (shadow_frame[i])
			shadow_frame[i] = 8'h00;
	endfunction

	// Update the shadow store for one accepted word; queue the byte a tick sends.
	function automatic void model_frame_word(input in_word_t w);
		out_word_t   nxt;
		int unsigned base;
		logic [7:0]  levels [3];
		logic [7:0]  mask;
		case (w.kind)
			KIND_WRITE: begin
				if (w.pixel_column < COLUMNS) begin
					levels = '{w.red_level, w.green_level, w.blue_level};
					mask = 8'h80 >> w.pixel_row;
					for (int c = 0; c < 3; c++) begin
						base = BYTES_PER_COLUMN * w.pixel_column + BYTES_PER_COLOR * c;
						// byte k carries intensity bit 7-k, MSB plane first
						for (int k = 0; k < 8; k++)
							shadow_frame[base + k] = levels[c][7 - k] ?
								(shadow_frame[base + k] | mask) :
								(shadow_frame[base + k] & ~mask);
					end
				end
			end
			KIND_START: begin
				shadow_scan_pos = 0;
				shadow_scanning = 1'b1;
			end
			KIND_CLEAR: begin
				wipe_shadow_frame();
				shadow_scan_pos = 0;
				shadow_scanning = 1'b1;
			end
			KIND_TICK: begin
				if (shadow_scanning) begin
					nxt.frame_byte = shadow_frame[shadow_scan_pos];
					nxt.last_byte = (shadow_scan_pos == FRAME_BYTES - 1);
					pending_bytes.push_back(nxt);
					if (nxt.last_byte) begin
						shadow_scanning = 1'b0;
						shadow_scan_pos = 0;
					end else begin
						shadow_scan_pos++;
					end
				end
			end
		endcase
	endfunction

	always @(posedge clk) begin : byte_check
		out_word_t want;
		if (arst_n && done) begin
			if (pending_bytes.size() == 0) begin
				report($sformatf("unexpected byte %02h last %0b",
					result.frame_byte, result.last_byte));
			end else begin
				want = pending_bytes.pop_front();
				if (result.frame_byte !== want.frame_byte)
					report($sformatf("frame_byte %02h, want %02h",
						result.frame_byte, want.frame_byte));
				if (result.last_byte !== want.last_byte)
					report($sformatf("last_byte %0b, want %0b",
						result.last_byte, want.last_byte));
			end
		end
	end

	function automatic in_word_t noise_word();
		logic [63:0]                 wide;
		logic [$bits(in_word_t)-1:0] raw;
		wide = {$urandom, $urandom};
		raw = wide[$bits(in_word_t)-1:0];
		return raw;
	endfunction

	function automatic in_word_t command_word(input kind_t k);
		in_word_t w;
		w = noise_word();
		w.kind = k;
		return w;
	endfunction

	function automatic in_word_t pixel_word(input logic [7:0] col, input logic [2:0] row,
			input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		in_word_t w;
		w.kind = KIND_WRITE;
		w.pixel_column = col;
		w.pixel_row = row;
		w.red_level = r;
		w.green_level = g;
		w.blue_level = b;
		return w;
	endfunction

	function automatic logic [7:0] pick_column();
		int unsigned roll = $urandom_range(0, 99);
		// favor low columns so the scans actually read back what was written
		if (roll < 60)
			return 8'($urandom_range(0, 31));
		if (roll < 90)
			return 8'($urandom_range(0, COLUMNS - 1));
		return 8'($urandom_range(COLUMNS, 255));
	endfunction

	function automatic in_word_t random_pixel_word();
		return pixel_word(pick_column(), 3'($urandom_range(0, 7)),
			8'($urandom), 8'($urandom), 8'($urandom));
	endfunction

	// Hold start high until the block takes the word; leave it high for a following word.
	task automatic send_word(input in_word_t w);
		@(negedge clk);
		start = 1'b1;
		in_word = w;
		forever begin
			@(posedge clk);
			if (busy === 1'b0)
				break;
		end
		model_frame_word(w);
	endtask

	task automatic pause_sender(input int unsigned cycles);
		@(negedge clk);
		start = 1'b0;
		in_word = noise_word();
		repeat (cycles - 1) @(negedge clk);
	endtask

	task automatic random_gap();
		if (!quiet_sender && $urandom_range(0, 99) < 15)
			pause_sender($urandom_range(1, 9));
	endtask

	task automatic drain_results();
		@(negedge clk);
		start = 1'b0;
		while (pending_bytes.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_idle_tick();
		send_word(command_word(KIND_TICK));
		pause_sender(3);
	endtask

	task automatic test_pixel_extremes();
		send_word(pixel_word(8'd0, 3'd0, 8'hFF, 8'h00, 8'hA5));
		send_word(pixel_word(8'd0, 3'd7, 8'h80, 8'h7F, 8'hFF));
		// out-of-range columns must leave the store alone
		send_word(pixel_word(8'(COLUMNS), 3'd7, 8'hFF, 8'hFF, 8'hFF));
		send_word(pixel_word(8'd255, 3'd0, 8'hFF, 8'hFF, 8'hFF));
		send_word(command_word(KIND_START));
		repeat (10) send_word(command_word(KIND_TICK));
	endtask

	task automatic test_restart_and_clear();
		// restart mid-scan, then clear mid-scan
		send_word(command_word(KIND_START));
		repeat (2) send_word(command_word(KIND_TICK));
		send_word(command_word(KIND_CLEAR));
		repeat (2) send_word(command_word(KIND_TICK));
		drain_results();
	endtask

	task automatic test_scan_with_writes();
		send_word(command_word(KIND_CLEAR));
		send_word(pixel_word(8'(COLUMNS - 1), 3'd7, 8'hFF, 8'h01, 8'h80));
		repeat (60) begin
			random_gap();
			send_word(random_pixel_word());
		end
		send_word(command_word(KIND_START));
		for (int i = 0; i < SCAN_TICKS; i++) begin
			random_gap();
			// writes land both ahead of and behind the scan position
			if ($urandom_range(0, 99) < 3)
				send_word(random_pixel_word());
			send_word(command_word(KIND_TICK));
		end
		drain_results();
	endtask

	task automatic test_random_traffic();
		int unsigned roll;
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i == RANDOM_WORDS / 2)
				drain_results();
			quiet_sender = (i >= RANDOM_WORDS - QUIET_WORDS);
			random_gap();
			roll = $urandom_range(0, 99);
			if (roll < 45)
				send_word(random_pixel_word());
			else if (roll < 90)
				send_word(command_word(KIND_TICK));
			else if (roll < 97)
				send_word(command_word(KIND_START));
			else
				send_word(command_word(KIND_CLEAR));
		end
	endtask

	initial begin
		start = 1'b0;
		in_word = '0;
		arst_n = 1'b0;
		wipe_shadow_frame();
		shadow_scan_pos = 0;
		shadow_scanning = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		test_idle_tick();
		test_pixel_extremes();
		test_restart_and_clear();
		test_scan_with_writes();
		test_random_traffic();

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
